FILE: design/ptmq_pkg.sv
// Shared status codes, operation codes and fixed port widths for the mailbox queues.
package ptmq_pkg;

  localparam int ID_BITS           = 5;
  localparam int PORT_PAYLOAD_BITS = 64;
  localparam int STATUS_BITS       = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ID  = 2'd1,
    ST_LIMIT   = 2'd2,
    ST_NO_TASK = 2'd3
  } status_t;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

endpackage

FILE: design/ptmq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ptmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/per_task_mailbox_queues.sv
// Top level: per-task circular mailbox queues over a shared payload RAM and a control RAM.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_operation, in_task_id, in_message_payload
//   out_     output     out_valid/out_stall out_status, out_receiver_id, out_received_payload
//
// One item at a time: in_stall is high from acceptance until the result is loaded into
// the output register. Control RAM data is read in S_CTRL; a send or a rejected item
// then goes to S_FIN, a successful receive first to S_PAY for the payload RAM read.
// The next item is taken while a finished result still waits under out_stall.
// Reset clears per-task valid bits in flops; an entry whose bit is clear reads as
// empty (head, tail and count zero). No clearing pass is run.
module per_task_mailbox_queues #(
  parameter int TASKS        = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      in_operation,
  input  logic [ptmq_pkg::ID_BITS-1:0]              in_task_id,
  input  logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0]    in_message_payload,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [ptmq_pkg::STATUS_BITS-1:0]          out_status,
  output logic [ptmq_pkg::ID_BITS-1:0]              out_receiver_id,
  output logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0]    out_received_payload
);

  localparam int TW    = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = TASKS * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int XW    = 9;
  localparam int CTW   = 2 * PW + CW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CTRL = 4'b0010,
    S_PAY  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic                    op_r;
  logic [ptmq_pkg::ID_BITS-1:0] id_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [TW-1:0]           q_r;

  ptmq_pkg::status_t       res_status_r, res_status_nxt;
  logic [ptmq_pkg::ID_BITS-1:0] res_rid_r, res_rid_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;

  logic                    out_valid_r, out_valid_nxt;
  ptmq_pkg::status_t       out_status_r;
  logic [ptmq_pkg::ID_BITS-1:0] out_rid_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;

  logic [TASKS-1:0]        ctrl_vld_r;

  logic                    accept;
  logic                    load_out;
  logic [XW-1:0]           in_id_m1;
  logic [TW-1:0]           in_q;

  logic                    ctrl_we;
  logic [CTW-1:0]          ctrl_wdata;
  logic [CTW-1:0]          ctrl_rdata;
  logic [CTW-1:0]          ctrl_cur;
  logic [PW-1:0]           head, tail, head_nxt, tail_nxt;
  logic [CW-1:0]           cnt, cnt_nxt;
  logic                    id_ok;

  logic                    pay_we, pay_re;
  logic [AW-1:0]           pay_addr;
  logic [PAYLOAD_BITS-1:0] pay_rdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign in_id_m1 = XW'(in_task_id) - XW'(1);
  assign in_q     = in_id_m1[TW-1:0];

  ptmq_ram #(.WIDTH(CTW), .DEPTH(TASKS)) u_ctrl_ram (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr (q_r),
    .wdata (ctrl_wdata),
    .re    (accept),
    .raddr (in_q),
    .rdata (ctrl_rdata)
  );

  ptmq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_addr),
    .wdata (pay_r),
    .re    (pay_re),
    .raddr (pay_addr),
    .rdata (pay_rdata)
  );

  // a task never written reads as an empty mailbox
  assign ctrl_cur = ctrl_vld_r[q_r] ? ctrl_rdata : '0;
  assign head     = ctrl_cur[CTW-1 -: PW];
  assign tail     = ctrl_cur[CW +: PW];
  assign cnt      = ctrl_cur[CW-1:0];
  assign id_ok    = (id_r != '0) && (XW'(id_r) <= XW'(TASKS));
  assign ctrl_wdata = {head_nxt, tail_nxt, cnt_nxt};

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_rid_nxt    = res_rid_r;
    res_pay_nxt    = res_pay_r;
    ctrl_we        = 1'b0;
    pay_we         = 1'b0;
    pay_re         = 1'b0;
    head_nxt       = head;
    tail_nxt       = tail;
    cnt_nxt        = cnt;
    pay_addr       = AW'(q_r) * AW'(QUEUE_DEPTH) + AW'(tail);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CTRL;
        end
      end
      S_CTRL: begin
        res_rid_nxt = '0;
        res_pay_nxt = '0;
        state_nxt   = S_FIN;
        if (op_r == ptmq_pkg::OP_SEND) begin
          if (!id_ok) begin
            res_status_nxt = ptmq_pkg::ST_BAD_ID;
          end else if (cnt >= CW'(QUEUE_DEPTH)) begin
            res_status_nxt = ptmq_pkg::ST_LIMIT;
          end else begin
            res_status_nxt = ptmq_pkg::ST_OK;
            pay_we   = 1'b1;
            ctrl_we  = 1'b1;
            tail_nxt = (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            cnt_nxt  = cnt + 1'b1;
          end
        end else begin
          if (id_r == '0) begin
            res_status_nxt = ptmq_pkg::ST_NO_TASK;
          end else if (!id_ok) begin
            res_status_nxt = ptmq_pkg::ST_BAD_ID;
          end else if (cnt == '0) begin
            res_status_nxt = ptmq_pkg::ST_LIMIT;
          end else begin
            res_status_nxt = ptmq_pkg::ST_OK;
            res_rid_nxt    = id_r;
            pay_re   = 1'b1;
            pay_addr = AW'(q_r) * AW'(QUEUE_DEPTH) + AW'(head);
            ctrl_we  = 1'b1;
            head_nxt = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            cnt_nxt  = cnt - 1'b1;
            state_nxt = S_PAY;
          end
        end
      end
      S_PAY: begin
        res_pay_nxt = pay_rdata;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ctrl_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctrl_we) begin
        ctrl_vld_r[q_r] <= 1'b1;
      end
    end
  end

  // item and result payload: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      id_r  <= in_task_id;
      pay_r <= in_message_payload[PAYLOAD_BITS-1:0];
      q_r   <= in_q;
    end
    res_status_r <= res_status_nxt;
    res_rid_r    <= res_rid_nxt;
    res_pay_r    <= res_pay_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_rid_r    <= res_rid_r;
      out_pay_r    <= res_pay_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_receiver_id      = out_rid_r;
  assign out_received_payload = (ptmq_pkg::PORT_PAYLOAD_BITS)'(out_pay_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_we |-> (cnt_nxt <= CW'(QUEUE_DEPTH)))
    else $error("mailbox fill count beyond queue depth");

  a_pay_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(pay_we && pay_re))
    else $error("payload RAM written and read in one cycle");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ptmq_pkg::ST_OK) |->
      (out_rid_r == '0 && out_pay_r == '0))
    else $error("rejected item carries receiver or payload");

  a_ctrl_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CTRL))
    else $error("control RAM data not consumed after transfer");

  a_recv_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAY) |-> (res_status_r == ptmq_pkg::ST_OK && res_rid_r == id_r))
    else $error("payload fetch without successful receive");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the per-task mailbox queues: directed rows, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TASKS       = 16;
  localparam int QDEPTH      = 8;
  localparam int RAND_ITEMS  = 1000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    ptmq_pkg::status_t                         status;
    logic [ptmq_pkg::ID_BITS-1:0]              rid;
    logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0]    payload;
  } reply_t;

  typedef struct {
    logic                                      op;
    logic [ptmq_pkg::ID_BITS-1:0]              id;
    logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0]    pay;
    bit                                        typed;
    reply_t                                    want;
  } stim_row_t;

  logic                                      clk = 1'b0;
  logic                                      rst_n;
  logic                                      in_valid;
  logic                                      in_stall;
  logic                                      in_operation;
  logic [ptmq_pkg::ID_BITS-1:0]              in_task_id;
  logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0]    in_message_payload;
  logic                                      out_valid;
  logic                                      out_stall;
  logic [ptmq_pkg::STATUS_BITS-1:0]          out_status;
  logic [ptmq_pkg::ID_BITS-1:0]              out_receiver_id;
  logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0]    out_received_payload;

  // mailbox shadow state
  logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] box_store [TASKS][QDEPTH];
  int                                     box_head  [TASKS];
  int                                     box_tail  [TASKS];
  int                                     box_count [TASKS];

  reply_t    replies_due[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;
  bit        stim_done = 1'b0;

  per_task_mailbox_queues #(
    .TASKS       (TASKS),
    .QUEUE_DEPTH (QDEPTH),
    .PAYLOAD_BITS(ptmq_pkg::PORT_PAYLOAD_BITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_task_id          (in_task_id),
    .in_message_payload  (in_message_payload),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_receiver_id     (out_receiver_id),
    .out_received_payload(out_received_payload)
  );

  always #4 clk = ~clk;

  function automatic reply_t predict_reply(logic op, logic [ptmq_pkg::ID_BITS-1:0] id,
                                           logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] pay);
    reply_t r;
    int     q;
    r.status  = ptmq_pkg::ST_OK;
    r.rid     = '0;
    r.payload = '0;
    q = int'(id) - 1;
    if (op == ptmq_pkg::OP_SEND) begin
      if (id == 0 || id > TASKS) begin
        r.status = ptmq_pkg::ST_BAD_ID;
      end else if (box_count[q] >= QDEPTH) begin
        r.status = ptmq_pkg::ST_LIMIT;
      end else begin
        box_store[q][box_tail[q]] = pay;
        box_tail[q] = (box_tail[q] + 1) % QDEPTH;
        box_count[q]++;
      end
    end else begin
      if (id == 0) begin
        r.status = ptmq_pkg::ST_NO_TASK;
      end else if (id > TASKS) begin
        r.status = ptmq_pkg::ST_BAD_ID;
      end else if (box_count[q] == 0) begin
        r.status = ptmq_pkg::ST_LIMIT;
      end else begin
        r.rid     = id;
        r.payload = box_store[q][box_head[q]];
        box_head[q] = (box_head[q] + 1) % QDEPTH;
        box_count[q]--;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic op, logic [ptmq_pkg::ID_BITS-1:0] id,
                                       logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] pay,
                                       bit typed, ptmq_pkg::status_t st,
                                       logic [ptmq_pkg::ID_BITS-1:0] rid,
                                       logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] rpay);
    stim_row_t s;
    s.op           = op;
    s.id           = id;
    s.pay          = pay;
    s.typed        = typed;
    s.want.status  = st;
    s.want.rid     = rid;
    s.want.payload = rpay;
    return s;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drop valid for a random gap once the current burst is used up.
  task automatic pace_sender();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one item, hold it until the transfer, then log the expected reply.
  task automatic offer_item(logic op, logic [ptmq_pkg::ID_BITS-1:0] id,
                            logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] pay, bit typed,
                            reply_t want);
    reply_t guess;
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_task_id         <= id;
    in_message_payload <= pay;
    do @(posedge clk); while (in_stall);
    guess = predict_reply(op, id, pay);
    replies_due.push_back(typed ? want : guess);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Compare each reply transfer with the oldest expectation.
  always @(posedge clk) begin
    reply_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("unexpected reply status", 64'(out_status), 64'd0);
      end else begin
        w = replies_due.pop_front();
        if (out_status !== w.status)
          flag_mismatch("status", 64'(out_status), 64'(w.status));
        if (out_receiver_id !== w.rid)
          flag_mismatch("receiver_id", 64'(out_receiver_id), 64'(w.rid));
        if (out_received_payload !== w.payload)
          flag_mismatch("received_payload", out_received_payload, w.payload);
      end
    end
  end

  // Receiver stall patterns, plus a long hold-off on request.
  initial begin
    int mode;
    int len;
    int tick;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        @(posedge clk);
        tick++;
        if (stim_done) begin
          out_stall <= 1'b0;
        end else if (hold_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          out_stall <= 1'b0;
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (tick % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] ones;
    stim_row_t                              row;
    reply_t                                 none;
    int                                     send_bias;
    int                                     pick;
    int                                     id_pick;
    logic                                   op;
    logic [ptmq_pkg::ID_BITS-1:0]           id;
    logic [ptmq_pkg::PORT_PAYLOAD_BITS-1:0] pay;

    ones = '1;
    none = '0;
    send_bias = 50;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_operation       = ptmq_pkg::OP_SEND;
    in_task_id         = '0;
    in_message_payload = '0;
    for (int t = 0; t < TASKS; t++) begin
      box_head[t]  = 0;
      box_tail[t]  = 0;
      box_count[t] = 0;
    end

    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd1,  '0,   1,
                                   ptmq_pkg::ST_LIMIT,   '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd0,  ones, 1,
                                   ptmq_pkg::ST_NO_TASK, '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd17, '0,   1,
                                   ptmq_pkg::ST_BAD_ID,  '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd31, ones, 1,
                                   ptmq_pkg::ST_BAD_ID,  '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd0,  ones, 1,
                                   ptmq_pkg::ST_BAD_ID,  '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd17, '0,   1,
                                   ptmq_pkg::ST_BAD_ID,  '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd31, ones, 1,
                                   ptmq_pkg::ST_BAD_ID,  '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd16, ones, 1,
                                   ptmq_pkg::ST_OK,      '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd1,  '0,   1,
                                   ptmq_pkg::ST_OK,      '0, '0));
    // fill mailbox 1 to the brim
    for (int k = 1; k < QDEPTH; k++)
      directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd1, {$urandom, $urandom}, 0,
                                     ptmq_pkg::ST_OK, '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd1,  ones, 1,
                                   ptmq_pkg::ST_LIMIT,   '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd16, '0,   1,
                                   ptmq_pkg::ST_OK,      5'd16, ones));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd16, '0,   1,
                                   ptmq_pkg::ST_LIMIT,   '0, '0));
    directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd1,  ones, 1,
                                   ptmq_pkg::ST_OK,      5'd1, '0));
    // reuse the first slot after the tail wrapped
    directed_rows.push_back(mk_row(ptmq_pkg::OP_SEND, 5'd1, 64'h5555_aaaa_5555_aaaa, 0,
                                   ptmq_pkg::ST_OK, '0, '0));
    for (int k = 0; k < 3; k++)
      directed_rows.push_back(mk_row(ptmq_pkg::OP_RECV, 5'd1, '0, 0,
                                     ptmq_pkg::ST_OK, '0, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      pace_sender();
      offer_item(row.op, row.id, row.pay, row.typed, row.want);
    end
    wait_drained();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 150 == 0) begin
        pick = $urandom_range(0, 2);
        send_bias = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
      end
      if (n == 300 || n == 700)
        hold_req = 1'b1;
      if (n == 500 || n == 850)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 10)
        id_pick = $urandom_range(0, 31);
      else if (pick < 55)
        id_pick = $urandom_range(1, 3);
      else
        id_pick = $urandom_range(1, TASKS);
      id = id_pick[ptmq_pkg::ID_BITS-1:0];
      op = ($urandom_range(0, 99) < send_bias) ? ptmq_pkg::OP_SEND : ptmq_pkg::OP_RECV;
      pick = $urandom_range(0, 19);
      pay = (pick == 0) ? '0 : (pick == 1) ? ones : {$urandom, $urandom};
      pace_sender();
      offer_item(op, id, pay, 1'b0, none);
    end

    wait_drained();
    stim_done = 1'b1;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
